/* src/pgba_pkg.sv */
// ----------------------------------------------------------------------------
// pgba_pkg
// Shared types, constants and codes of the particle grid binning block.
// ----------------------------------------------------------------------------
`default_nettype none
package pgba_pkg;

    localparam int GRID_X_DEF = 32;
    localparam int GRID_Y_DEF = 32;
    localparam int GRID_Z_DEF = 32;

    localparam int CELL_W  = 15;
    localparam int COUNT_W = 16;
    localparam int SUM_W   = 48;
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_DEPOSIT = 2'd0,
        CMD_READ    = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_INV_X    = 3'd3,
        REG_INV_Y    = 3'd4,
        REG_INV_Z    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] origin_x;
        logic [DATA_W-1:0] origin_y;
        logic [DATA_W-1:0] origin_z;
        logic [DATA_W-1:0] inv_x;
        logic [DATA_W-1:0] inv_y;
        logic [DATA_W-1:0] inv_z;
    } cfg_t;

    // Classified work item passed from front end to back end.
    typedef struct packed {
        cmd_t                     cmd;
        logic                     in_grid;
        logic [CELL_W-1:0]        cell_idx;
        logic signed [DATA_W-1:0] value;
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD,
        BK_UPD,
        BK_DIV,
        BK_CLR,
        BK_OUT
    } bk_state_t;

endpackage
`default_nettype wire

/* src/pgba_if.sv */
// ----------------------------------------------------------------------------
// pgba_if
// Valid/ready channel interfaces for requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface pgba_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           command;
    logic signed [pgba_pkg::DATA_W-1:0]   pos_x;
    logic signed [pgba_pkg::DATA_W-1:0]   pos_y;
    logic signed [pgba_pkg::DATA_W-1:0]   pos_z;
    logic signed [pgba_pkg::DATA_W-1:0]   sample_value;
    logic [pgba_pkg::CELL_W-1:0]          read_cell;
    modport source (output valid, command, pos_x, pos_y, pos_z, sample_value, read_cell,
                    input ready);
    modport sink   (input valid, command, pos_x, pos_y, pos_z, sample_value, read_cell,
                    output ready);
endinterface

interface pgba_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [pgba_pkg::CELL_W-1:0]          cell_index;
    logic [pgba_pkg::COUNT_W-1:0]         particle_count;
    logic signed [pgba_pkg::DATA_W-1:0]   mean_value;
    logic                                 count_saturated;
    modport source (output valid, cell_index, particle_count, mean_value, count_saturated,
                    input ready);
    modport sink   (input valid, cell_index, particle_count, mean_value, count_saturated,
                    output ready);
endinterface

interface pgba_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pgba_pkg::CFG_IDX_W-1:0]     index;
    logic [pgba_pkg::DATA_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/particle_grid_binning_average.sv */
// ----------------------------------------------------------------------------
// particle_grid_binning_average
// Nearest-grid-point binning of particles with per-cell mean readout.
// ----------------------------------------------------------------------------
// The back end holds one item at a time and takes the next only once it has
// finished: a deposit passes a memory read-modify-write, a read of a filled cell
// in the grid a 48-step divider, a clear a sweep that zeroes all GRID_X*GRID_Y*GRID_Z cells.
// Reset: registers to origin 0 and unit inverse cell size, then a sweep zeroes
// every cell of the memory; no result is emitted.
`default_nettype none
module particle_grid_binning_average #(
    parameter int GRID_X = pgba_pkg::GRID_X_DEF,
    parameter int GRID_Y = pgba_pkg::GRID_Y_DEF,
    parameter int GRID_Z = pgba_pkg::GRID_Z_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pgba_req_if.sink   req,
    pgba_rsp_if.source rsp,
    pgba_cfg_if.sink   cfg
);
    pgba_pkg::cfg_t cfg_reg;
    logic           op_valid, op_ready, q_valid, q_ready;
    pgba_pkg::op_t  op, q_op;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.origin_z <= '0;
            cfg_reg.inv_x    <= 32'd65536;
            cfg_reg.inv_y    <= 32'd65536;
            cfg_reg.inv_z    <= 32'd65536;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pgba_pkg::REG_ORIGIN_X: cfg_reg.origin_x <= cfg.data;
                pgba_pkg::REG_ORIGIN_Y: cfg_reg.origin_y <= cfg.data;
                pgba_pkg::REG_ORIGIN_Z: cfg_reg.origin_z <= cfg.data;
                pgba_pkg::REG_INV_X:    cfg_reg.inv_x    <= cfg.data;
                pgba_pkg::REG_INV_Y:    cfg_reg.inv_y    <= cfg.data;
                pgba_pkg::REG_INV_Z:    cfg_reg.inv_z    <= cfg.data;
                default: ;
            endcase
        end
    end

    // Front end: classify and compute the target cell.
    pgba_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
        .clk(clk), .rst_n(rst_n), .req(req), .cfg(cfg_reg),
        .op_valid(op_valid), .op_ready(op_ready), .op(op)
    );

    // Decouple the pipelined front from the multi-cycle back end.
    pgba_queue #(.DEPTH(pgba_pkg::QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(op_valid), .in_ready(op_ready), .in_op(op),
        .out_valid(q_valid), .out_ready(q_ready), .out_op(q_op)
    );

    // Back end: memory update, divide, clear sweep, result register.
    pgba_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
        .clk(clk), .rst_n(rst_n),
        .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
        .rsp(rsp)
    );
endmodule
`default_nettype wire

/* src/pgba_front.sv */
// ----------------------------------------------------------------------------
// pgba_front
// Accept requests, compute the cell index of deposits over three stages.
// ----------------------------------------------------------------------------
`default_nettype none
module pgba_front #(
    parameter int GRID_X = pgba_pkg::GRID_X_DEF,
    parameter int GRID_Y = pgba_pkg::GRID_Y_DEF,
    parameter int GRID_Z = pgba_pkg::GRID_Z_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    pgba_req_if.sink           req,
    input  wire pgba_pkg::cfg_t cfg,
    output logic               op_valid,
    input  wire logic          op_ready,
    output pgba_pkg::op_t      op
);
    localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int ZW = $clog2(GRID_Z);

    // Stage 1: differences. Stage 2: products. Stage 3: clamp and flatten.
    logic                              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    pgba_pkg::cmd_t                    s1_cmd_reg, s2_cmd_reg, s3_cmd_reg;
    logic signed [pgba_pkg::DATA_W:0]  s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [pgba_pkg::DATA_W-1:0]       s1_val_reg, s2_val_reg, s3_val_reg;
    logic [pgba_pkg::CELL_W-1:0]       s1_rc_reg, s2_rc_reg;
    logic [63:0]                       s2_px_reg, s2_py_reg, s2_pz_reg;
    logic                              s2_nx_reg, s2_ny_reg, s2_nz_reg;
    logic [pgba_pkg::CELL_W-1:0]       s3_cell_reg;
    logic                              s3_in_reg;

    logic adv1, adv2, adv3;
    assign adv3 = !s3_valid_reg || op_ready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign req.ready = adv1;

    function automatic logic [31:0] clampi(input logic neg, input logic [63:0] p,
                                           input int size);
        logic [31:0] hi;
        hi = p[63:32];
        if (neg)
            return 32'd0;
        else if (hi > 32'(size - 1))
            return 32'(size - 1);
        else
            return hi;
    endfunction

    logic [31:0] ix, iy, iz, flat;
    always_comb
    begin
        ix = clampi(s2_nx_reg, s2_px_reg, GRID_X);
        iy = clampi(s2_ny_reg, s2_py_reg, GRID_Y);
        iz = clampi(s2_nz_reg, s2_pz_reg, GRID_Z);
        flat = 32'(ix[XW-1:0]) + 32'(iy[YW-1:0]) * 32'(GRID_X)
             + 32'(iz[ZW-1:0]) * 32'(GRID_X * GRID_Y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= req.valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_cmd_reg <= pgba_pkg::cmd_t'(req.command);
            s1_dx_reg  <= 33'(req.pos_x) - 33'(signed'(cfg.origin_x));
            s1_dy_reg  <= 33'(req.pos_y) - 33'(signed'(cfg.origin_y));
            s1_dz_reg  <= 33'(req.pos_z) - 33'(signed'(cfg.origin_z));
            s1_val_reg <= req.sample_value;
            s1_rc_reg  <= req.read_cell;
        end
        if (adv2)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_nx_reg  <= s1_dx_reg[32];
            s2_ny_reg  <= s1_dy_reg[32];
            s2_nz_reg  <= s1_dz_reg[32];
            s2_px_reg  <= 64'(s1_dx_reg[31:0]) * 64'(cfg.inv_x);
            s2_py_reg  <= 64'(s1_dy_reg[31:0]) * 64'(cfg.inv_y);
            s2_pz_reg  <= 64'(s1_dz_reg[31:0]) * 64'(cfg.inv_z);
            s2_val_reg <= s1_val_reg;
            s2_rc_reg  <= s1_rc_reg;
        end
        if (adv3)
        begin
            s3_cmd_reg <= s2_cmd_reg;
            s3_val_reg <= s2_val_reg;
            if (s2_cmd_reg == pgba_pkg::CMD_DEPOSIT)
            begin
                s3_cell_reg <= flat[pgba_pkg::CELL_W-1:0];
                s3_in_reg   <= 1'b1;
            end
            else
            begin
                s3_cell_reg <= s2_rc_reg;
                s3_in_reg   <= 32'(s2_rc_reg) < 32'(NCELLS);
            end
        end
    end

    assign op_valid     = s3_valid_reg;
    assign op.cmd       = s3_cmd_reg;
    assign op.in_grid   = s3_in_reg;
    assign op.cell_idx  = s3_cell_reg;
    assign op.value     = s3_val_reg;
endmodule
`default_nettype wire

/* src/pgba_queue.sv */
// ----------------------------------------------------------------------------
// pgba_queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pgba_queue #(
    parameter int DEPTH = pgba_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pgba_pkg::op_t in_op,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pgba_pkg::op_t      out_op
);
    localparam int AW = $clog2(DEPTH);
    pgba_pkg::op_t       mem_reg [DEPTH];
    logic [AW-1:0]       wr_reg, rd_reg;
    logic [AW:0]         cnt_reg;
    logic                push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_op    = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= in_op;
    end
endmodule
`default_nettype wire

/* src/pgba_back.sv */
// ----------------------------------------------------------------------------
// pgba_back
// Cell memory, read-modify-write of deposits, mean divider and clear sweep.
// ----------------------------------------------------------------------------
`default_nettype none
module pgba_back #(
    parameter int GRID_X = pgba_pkg::GRID_X_DEF,
    parameter int GRID_Y = pgba_pkg::GRID_Y_DEF,
    parameter int GRID_Z = pgba_pkg::GRID_Z_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          op_valid,
    output logic               op_ready,
    input  wire pgba_pkg::op_t op,
    pgba_rsp_if.source         rsp
);
    localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW = $clog2(NCELLS);
    localparam int CW = pgba_pkg::COUNT_W;
    localparam int SW = pgba_pkg::SUM_W;
    localparam int DW = pgba_pkg::DATA_W;

    logic [CW-1:0] cnt_mem [NCELLS];
    logic [SW-1:0] sum_mem [NCELLS];

    pgba_pkg::bk_state_t state_reg, state_next;
    pgba_pkg::op_t       op_reg;
    logic [CW-1:0]       rd_cnt_reg;
    logic [SW-1:0]       rd_sum_reg;
    logic [AW:0]         clr_reg, clr_next;
    logic [5:0]          bit_reg, bit_next;
    logic [SW-1:0]       quo_reg, quo_next, mag_reg, mag_next;
    logic [CW:0]         rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic                rv_reg, rv_next;
    logic [pgba_pkg::CELL_W-1:0] ri_reg, ri_next;
    logic [CW-1:0]       rc_reg, rc_next;
    logic [DW-1:0]       rm_reg, rm_next;
    logic                rs_reg, rs_next;
    logic                take, we, rd_en;
    logic [AW-1:0]       we_addr;
    logic [CW-1:0]       we_cnt;
    logic [SW-1:0]       we_sum, newsum;
    logic [CW:0]         trial;
    logic [SW-1:0]       qfin;
    logic                boot_reg;

    assign take     = op_valid && op_ready;
    assign newsum   = rd_sum_reg + SW'(signed'(op_reg.value));
    assign trial    = {rem_reg[CW-1:0], mag_reg[SW-1]};
    assign qfin     = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pgba_pkg::BK_CLR;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) op_reg <= op;
        if (rd_en)
        begin
            rd_cnt_reg <= cnt_mem[op_reg.cell_idx[AW-1:0]];
            rd_sum_reg <= sum_mem[op_reg.cell_idx[AW-1:0]];
        end
        if (we)
        begin
            cnt_mem[we_addr] <= we_cnt;
            sum_mem[we_addr] <= we_sum;
        end
        bit_reg <= bit_next;
        quo_reg <= quo_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        ri_reg  <= ri_next;
        rc_reg  <= rc_next;
        rm_reg  <= rm_next;
        rs_reg  <= rs_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        bit_next   = bit_reg;
        quo_next   = quo_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        rv_next    = rv_reg && !rsp.ready;
        ri_next    = ri_reg;
        rc_next    = rc_reg;
        rm_next    = rm_reg;
        rs_next    = rs_reg;
        op_ready   = 1'b0;
        rd_en      = 1'b0;
        we         = 1'b0;
        we_addr    = op_reg.cell_idx[AW-1:0];
        we_cnt     = rd_cnt_reg + 1'b1;
        we_sum     = newsum;
        unique case (state_reg)
            pgba_pkg::BK_IDLE:
            begin
                op_ready = !rv_reg || rsp.ready;
                if (take) state_next = pgba_pkg::BK_RD;
            end
            pgba_pkg::BK_RD:
            begin
                rd_en = 1'b1;
                ri_next = op_reg.cell_idx;
                rc_next = '0;
                rm_next = '0;
                rs_next = 1'b0;
                unique case (op_reg.cmd)
                    pgba_pkg::CMD_DEPOSIT: state_next = pgba_pkg::BK_UPD;
                    pgba_pkg::CMD_READ:
                        state_next = op_reg.in_grid ? pgba_pkg::BK_DIV : pgba_pkg::BK_OUT;
                    pgba_pkg::CMD_CLEAR:
                    begin
                        ri_next    = '0;
                        clr_next   = '0;
                        state_next = pgba_pkg::BK_CLR;
                    end
                    default:
                    begin
                        ri_next    = '0;
                        state_next = pgba_pkg::BK_OUT;
                    end
                endcase
                bit_next = 6'(SW + 1);
            end
            pgba_pkg::BK_UPD:
            begin
                we      = rd_cnt_reg != pgba_pkg::COUNT_MAX;
                rc_next = we ? we_cnt : rd_cnt_reg;
                rs_next = we_cnt == pgba_pkg::COUNT_MAX || !we;
                state_next = pgba_pkg::BK_OUT;
            end
            pgba_pkg::BK_DIV:
            begin
                // Restoring divide of |sum| by count, one bit per cycle.
                if (bit_reg == 6'(SW + 1))
                begin
                    neg_next = rd_sum_reg[SW-1];
                    mag_next = rd_sum_reg[SW-1] ? (~rd_sum_reg + 1'b1) : rd_sum_reg;
                    rem_next = '0;
                    quo_next = '0;
                    rc_next  = rd_cnt_reg;
                    rs_next  = rd_cnt_reg == pgba_pkg::COUNT_MAX;
                    bit_next = bit_reg - 1'b1;
                    if (rd_cnt_reg == '0) state_next = pgba_pkg::BK_OUT;
                end
                else
                begin
                    mag_next = {mag_reg[SW-2:0], 1'b0};
                    if (trial >= {1'b0, rc_reg})
                    begin
                        rem_next = trial - {1'b0, rc_reg};
                        quo_next = {quo_reg[SW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial;
                        quo_next = {quo_reg[SW-2:0], 1'b0};
                    end
                    bit_next = bit_reg - 1'b1;
                    if (bit_reg == '0)
                    begin
                        bit_next   = bit_reg;
                        mag_next   = mag_reg;
                        rem_next   = rem_reg;
                        quo_next   = quo_reg;
                        rm_next    = qfin[DW-1:0];
                        state_next = pgba_pkg::BK_OUT;
                    end
                end
            end
            pgba_pkg::BK_CLR:
            begin
                we      = 1'b1;
                we_addr = clr_reg[AW-1:0];
                we_cnt  = '0;
                we_sum  = '0;
                clr_next = clr_reg + 1'b1;
                // Power-up sweep returns to idle; a clear request reports its result.
                if (clr_reg == (AW+1)'(NCELLS - 1))
                    state_next = boot_reg ? pgba_pkg::BK_IDLE : pgba_pkg::BK_OUT;
            end
            pgba_pkg::BK_OUT:
            begin
                if (!rv_reg || rsp.ready)
                begin
                    rv_next    = 1'b1;
                    state_next = pgba_pkg::BK_IDLE;
                end
            end
            default: state_next = pgba_pkg::BK_IDLE;
        endcase
    end

    // The reset sweep must not emit a result: track it with a flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            boot_reg <= 1'b1;
        else if (state_reg == pgba_pkg::BK_CLR && clr_reg == (AW+1)'(NCELLS - 1))
            boot_reg <= 1'b0;
    end

    assign rsp.valid           = rv_reg && !boot_reg;
    assign rsp.cell_index      = ri_reg;
    assign rsp.particle_count  = rc_reg;
    assign rsp.mean_value      = rm_reg;
    assign rsp.count_saturated = rs_reg;
endmodule
`default_nettype wire
